// ----- rtl/core/cpp_pkg.sv -----
// shared types, constants and arithmetic helpers for the point projection block
package cpp_pkg;

   localparam int DIV_STEPS  = 60;
   localparam int ADDR_WIDTH = 5;

   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
   localparam logic signed [63:0] HALF_Q28 = 64'sd134217728;
   localparam logic signed [35:0] MAX_S32 = 36'sd2147483647;
   localparam logic signed [35:0] MIN_S32 = -36'sd2147483648;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DIV_ERR = 2'd1,
      STATUS_SAT     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_RADIAL_K1     = 3'd0,
      REG_RADIAL_K2     = 3'd1,
      REG_RADIAL_K3     = 3'd2,
      REG_TANGENTIAL_P1 = 3'd3,
      REG_TANGENTIAL_P2 = 3'd4,
      REG_FOCAL_X       = 3'd5,
      REG_FOCAL_Y       = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
      logic [30:0]        fx;
      logic [30:0]        fy;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } sat_res_type;

   typedef struct packed {
      logic [DIV_STEPS-1:0] nqx;
      logic [31:0]          remx;
      logic [DIV_STEPS-1:0] nqy;
      logic [31:0]          remy;
      logic [31:0]          den;
      logic                 negx;
      logic                 negy;
      logic                 zero;
   } div_word_type;

   typedef struct packed {
      logic [DIV_STEPS-1:0] nq;
      logic [31:0]          rem;
   } div_step_type;

   function automatic logic signed [35:0] sx36(input logic signed [31:0] a);
      sx36 = $signed({{4{a[31]}}, a});
   endfunction

   function automatic sat_res_type sat36(input logic signed [35:0] q);
      sat_res_type r;
      if (q > MAX_S32) begin
         r.val = 32'sh7fffffff;
         r.sat = 1'b1;
      end else if (q < MIN_S32) begin
         r.val = 32'sh80000000;
         r.sat = 1'b1;
      end else begin
         r.val = q[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   // q4.28 product, rounded half up, saturated
   function automatic sat_res_type mulq(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [35:0] q;
      p = a * b;
      p = p + HALF_Q28;
      q = p[63:28];
      return sat36(q);
   endfunction

   // one restoring division step
   function automatic div_step_type div_step(input logic [31:0] rem,
                                             input logic [DIV_STEPS-1:0] nq,
                                             input logic [31:0] den);
      logic [32:0]  trial;
      logic [32:0]  diff;
      div_step_type r;
      trial = {rem, nq[DIV_STEPS-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         r.rem = diff[31:0];
         r.nq  = {nq[DIV_STEPS-2:0], 1'b1};
      end else begin
         r.rem = trial[31:0];
         r.nq  = {nq[DIV_STEPS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sat_res_type sat_quot(input logic [DIV_STEPS-1:0] mag,
                                            input logic neg);
      sat_res_type r;
      if (neg) begin
         if (mag > DIV_STEPS'(64'd2147483648)) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
         end else begin
            r.val = ~mag[31:0] + 32'd1;
            r.sat = 1'b0;
         end
      end else begin
         if (mag > DIV_STEPS'(64'd2147483647)) begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
         end else begin
            r.val = mag[31:0];
            r.sat = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/camera_point_projection_top.sv -----
// pinhole projection with radial and tangential lens distortion, top level
// pipeline from an accepted req word to its rsp word, in order:
//   (1 entry, 60 divider bit steps, 1 quotient saturate, 9 distortion/scale stages)
// throughput: one word per cycle; the whole pipeline advances together and holds
//   while a finished rsp word waits, so req_ready drops only then
// reset: synchronous, clears all valid bits; registers return to their default lens
module camera_point_projection_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_point_x,
   input  logic signed [31:0]             req_point_y,
   input  logic signed [31:0]             req_point_z,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_pixel_u,
   output logic signed [31:0]             rsp_pixel_v,
   output logic [1:0]                     rsp_status,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cpp_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import cpp_pkg::*;

   cfg_type            cfg;
   logic               en;
   logic               div_valid, div_sat, div_zero;
   logic signed [31:0] div_nx, div_ny;
   status_type         status;

   // the pipeline moves whenever the output register is empty or being drained
   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   // lens and focal registers
   cpp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // normalized coordinates nx = -x/z, ny = -y/z in q4.28, one quotient bit per stage
   cpp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .in_z      (req_point_z),
      .out_valid (div_valid),
      .out_nx    (div_nx),
      .out_ny    (div_ny),
      .out_sat   (div_sat),
      .out_zero  (div_zero)
   );

   // distortion polynomial, tangential terms and focal scaling; last stage is the rsp register
   cpp_distort u_dist (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg),
      .in_valid   (div_valid),
      .in_nx      (div_nx),
      .in_ny      (div_ny),
      .in_sat     (div_sat),
      .in_zero    (div_zero),
      .out_valid  (rsp_valid),
      .out_u      (rsp_pixel_u),
      .out_v      (rsp_pixel_v),
      .out_status (status)
   );

   assign rsp_status = status;

`ifndef NO_ASSERTIONS
   a_div_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_DIV_ERR |-> rsp_pixel_u == 32'sd0 && rsp_pixel_v == 32'sd0)
      else $error("depth error word carries nonzero pixel");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word present right after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && !$past(req_ready))
      else $error("pipeline moved while stalled");
`endif

endmodule

// ----- rtl/core/cpp_csr.sv -----
// configuration registers behind the apb-style port
module cpp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cpp_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output cpp_pkg::cfg_type                cfg
);
   import cpp_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx        = reg_index_type'(csr_paddr[ADDR_WIDTH-1:2]);
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_RADIAL_K1:     cfg_in.k1 = csr_pwdata;
            REG_RADIAL_K2:     cfg_in.k2 = csr_pwdata;
            REG_RADIAL_K3:     cfg_in.k3 = csr_pwdata;
            REG_TANGENTIAL_P1: cfg_in.p1 = csr_pwdata;
            REG_TANGENTIAL_P2: cfg_in.p2 = csr_pwdata;
            REG_FOCAL_X:       cfg_in.fx = csr_pwdata[30:0];
            REG_FOCAL_Y:       cfg_in.fy = csr_pwdata[30:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RADIAL_K1:     csr_prdata = cfg_ff.k1;
         REG_RADIAL_K2:     csr_prdata = cfg_ff.k2;
         REG_RADIAL_K3:     csr_prdata = cfg_ff.k3;
         REG_TANGENTIAL_P1: csr_prdata = cfg_ff.p1;
         REG_TANGENTIAL_P2: csr_prdata = cfg_ff.p2;
         REG_FOCAL_X:       csr_prdata = {1'b0, cfg_ff.fx};
         REG_FOCAL_Y:       csr_prdata = {1'b0, cfg_ff.fy};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k1 <= 32'sd50394975;
         cfg_ff.k2 <= -32'sd378555574;
         cfg_ff.k3 <= 32'sd821320903;
         cfg_ff.p1 <= -32'sd775246;
         cfg_ff.p2 <= -32'sd347575;
         cfg_ff.fx <= 31'd31968448;
         cfg_ff.fy <= 31'd32140826;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/cpp_divider.sv -----
// pipelined restoring divider forming -x/z and -y/z in q4.28
module cpp_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   output logic               out_valid,
   output logic signed [31:0] out_nx,
   output logic signed [31:0] out_ny,
   output logic               out_sat,
   output logic               out_zero
);
   import cpp_pkg::*;

   div_word_type stg_ff [0:DIV_STEPS];
   logic         vld_ff [0:DIV_STEPS];
   div_word_type entry_in;
   logic [31:0]  absx, absy, absz;
   sat_res_type  qx, qy;
   logic signed [31:0] nx_ff, ny_ff;
   logic         sat_ff, zero_ff, ovld_ff;

   assign absx = in_x[31] ? (~in_x + 32'd1) : in_x;
   assign absy = in_y[31] ? (~in_y + 32'd1) : in_y;
   assign absz = in_z[31] ? (~in_z + 32'd1) : in_z;

   always_comb begin
      entry_in.nqx  = {absx, 28'd0};
      entry_in.remx = 32'd0;
      entry_in.nqy  = {absy, 28'd0};
      entry_in.remy = 32'd0;
      entry_in.den  = absz;
      entry_in.negx = ~in_x[31] ^ in_z[31];
      entry_in.negy = ~in_y[31] ^ in_z[31];
      entry_in.zero = (in_z == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff[0] <= entry_in;
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      div_step_type sx, sy;
      div_word_type step_in;
      assign sx = div_step(stg_ff[s-1].remx, stg_ff[s-1].nqx, stg_ff[s-1].den);
      assign sy = div_step(stg_ff[s-1].remy, stg_ff[s-1].nqy, stg_ff[s-1].den);
      always_comb begin
         step_in      = stg_ff[s-1];
         step_in.nqx  = sx.nq;
         step_in.remx = sx.rem;
         step_in.nqy  = sy.nq;
         step_in.remy = sy.rem;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[s] <= step_in;
         end
      end
   end

   assign qx = sat_quot(stg_ff[DIV_STEPS].nqx, stg_ff[DIV_STEPS].negx);
   assign qy = sat_quot(stg_ff[DIV_STEPS].nqy, stg_ff[DIV_STEPS].negy);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff   <= qx.val;
         ny_ff   <= qy.val;
         sat_ff  <= qx.sat | qy.sat;
         zero_ff <= stg_ff[DIV_STEPS].zero;
      end
   end

   assign out_valid = ovld_ff;
   assign out_nx    = nx_ff;
   assign out_ny    = ny_ff;
   assign out_sat   = sat_ff;
   assign out_zero  = zero_ff;

`ifndef NO_ASSERTIONS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && !stg_ff[DIV_STEPS].zero |->
         stg_ff[DIV_STEPS].remx < stg_ff[DIV_STEPS].den &&
         stg_ff[DIV_STEPS].remy < stg_ff[DIV_STEPS].den)
      else $error("divider remainder out of range");
`endif

endmodule

// ----- rtl/core/cpp_distort.sv -----
// distortion polynomial and focal scaling, one multiply deep per stage
module cpp_distort (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  cpp_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  logic signed [31:0] in_nx,
   input  logic signed [31:0] in_ny,
   input  logic               in_sat,
   input  logic               in_zero,
   output logic               out_valid,
   output logic signed [31:0] out_u,
   output logic signed [31:0] out_v,
   output cpp_pkg::status_type out_status
);
   import cpp_pkg::*;

   localparam int NSTG = 9;

   logic vld_ff [1:NSTG];
   logic sat_ff [1:NSTG-1];
   logic zro_ff [1:NSTG-1];

   logic signed [31:0] s1_xx_ff, s1_yy_ff, s1_xy_ff, s1_nx_ff, s1_ny_ff;
   logic signed [31:0] s2_r2_ff, s2_xx_ff, s2_yy_ff, s2_xy_ff, s2_nx_ff, s2_ny_ff;
   logic signed [31:0] s3_r4_ff, s3_r2_ff, s3_k1_ff, s3_sx_ff, s3_sy_ff;
   logic signed [31:0] s3_p1_ff, s3_p2_ff, s3_nx_ff, s3_ny_ff;
   logic signed [31:0] s4_r6_ff, s4_k2_ff, s4_k1_ff, s4_tx_ff, s4_ty_ff;
   logic signed [31:0] s4_p1_ff, s4_p2_ff, s4_nx_ff, s4_ny_ff;
   logic signed [31:0] s5_k3_ff, s5_k2_ff, s5_k1_ff, s5_tx_ff, s5_ty_ff;
   logic signed [31:0] s5_p1_ff, s5_p2_ff, s5_nx_ff, s5_ny_ff;
   logic signed [31:0] s6_kr_ff, s6_tx_ff, s6_ty_ff, s6_p1_ff, s6_p2_ff;
   logic signed [31:0] s6_nx_ff, s6_ny_ff;
   logic signed [31:0] s7_a_ff, s7_b_ff, s7_tx_ff, s7_ty_ff, s7_p1_ff, s7_p2_ff;
   logic signed [31:0] s8_dx_ff, s8_dy_ff;
   logic signed [31:0] u_ff, v_ff;
   status_type         status_ff;

   sat_res_type m1xx, m1yy, m1xy;
   sat_res_type a2r2;
   sat_res_type m3r4, m3k1, a3sx, a3sy, m3p1, m3p2;
   sat_res_type m4r6, m4k2, m4tx, m4ty;
   sat_res_type m5k3;
   sat_res_type a6kr;
   sat_res_type m7a, m7b;
   sat_res_type a8dx, a8dy;
   sat_res_type m9u, m9v;

   assign m1xx = mulq(in_nx, in_nx);
   assign m1yy = mulq(in_ny, in_ny);
   assign m1xy = mulq(in_nx, in_ny);
   assign a2r2 = sat36(sx36(s1_xx_ff) + sx36(s1_yy_ff));
   assign m3r4 = mulq(s2_r2_ff, s2_r2_ff);
   assign m3k1 = mulq(cfg.k1, s2_r2_ff);
   assign a3sx = sat36(sx36(s2_r2_ff) + (sx36(s2_xx_ff) <<< 1));
   assign a3sy = sat36(sx36(s2_r2_ff) + (sx36(s2_yy_ff) <<< 1));
   assign m3p1 = mulq(cfg.p1, s2_xy_ff);
   assign m3p2 = mulq(cfg.p2, s2_xy_ff);
   assign m4r6 = mulq(s3_r4_ff, s3_r2_ff);
   assign m4k2 = mulq(cfg.k2, s3_r4_ff);
   assign m4tx = mulq(cfg.p2, s3_sx_ff);
   assign m4ty = mulq(cfg.p1, s3_sy_ff);
   assign m5k3 = mulq(cfg.k3, s4_r6_ff);
   assign a6kr = sat36(ONE_Q28 + sx36(s5_k1_ff) + sx36(s5_k2_ff) + sx36(s5_k3_ff));
   assign m7a  = mulq(s6_nx_ff, s6_kr_ff);
   assign m7b  = mulq(s6_ny_ff, s6_kr_ff);
   assign a8dx = sat36(sx36(s7_a_ff) + (sx36(s7_p1_ff) <<< 1) + sx36(s7_tx_ff));
   assign a8dy = sat36(sx36(s7_b_ff) + (sx36(s7_p2_ff) <<< 1) + sx36(s7_ty_ff));
   assign m9u  = mulq($signed({1'b0, cfg.fx}), s8_dx_ff);
   assign m9v  = mulq($signed({1'b0, cfg.fy}), s8_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NSTG; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[1] <= in_valid;
         for (int i = 2; i <= NSTG; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zro_ff[1] <= in_zero;
         for (int i = 2; i <= NSTG-1; i++) begin
            zro_ff[i] <= zro_ff[i-1];
         end
         sat_ff[1] <= in_sat | m1xx.sat | m1yy.sat | m1xy.sat;
         sat_ff[2] <= sat_ff[1] | a2r2.sat;
         sat_ff[3] <= sat_ff[2] | m3r4.sat | m3k1.sat | a3sx.sat | a3sy.sat
                      | m3p1.sat | m3p2.sat;
         sat_ff[4] <= sat_ff[3] | m4r6.sat | m4k2.sat | m4tx.sat | m4ty.sat;
         sat_ff[5] <= sat_ff[4] | m5k3.sat;
         sat_ff[6] <= sat_ff[5] | a6kr.sat;
         sat_ff[7] <= sat_ff[6] | m7a.sat | m7b.sat;
         sat_ff[8] <= sat_ff[7] | a8dx.sat | a8dy.sat;

         s1_xx_ff <= m1xx.val;
         s1_yy_ff <= m1yy.val;
         s1_xy_ff <= m1xy.val;
         s1_nx_ff <= in_nx;
         s1_ny_ff <= in_ny;

         s2_r2_ff <= a2r2.val;
         s2_xx_ff <= s1_xx_ff;
         s2_yy_ff <= s1_yy_ff;
         s2_xy_ff <= s1_xy_ff;
         s2_nx_ff <= s1_nx_ff;
         s2_ny_ff <= s1_ny_ff;

         s3_r4_ff <= m3r4.val;
         s3_r2_ff <= s2_r2_ff;
         s3_k1_ff <= m3k1.val;
         s3_sx_ff <= a3sx.val;
         s3_sy_ff <= a3sy.val;
         s3_p1_ff <= m3p1.val;
         s3_p2_ff <= m3p2.val;
         s3_nx_ff <= s2_nx_ff;
         s3_ny_ff <= s2_ny_ff;

         s4_r6_ff <= m4r6.val;
         s4_k2_ff <= m4k2.val;
         s4_k1_ff <= s3_k1_ff;
         s4_tx_ff <= m4tx.val;
         s4_ty_ff <= m4ty.val;
         s4_p1_ff <= s3_p1_ff;
         s4_p2_ff <= s3_p2_ff;
         s4_nx_ff <= s3_nx_ff;
         s4_ny_ff <= s3_ny_ff;

         s5_k3_ff <= m5k3.val;
         s5_k2_ff <= s4_k2_ff;
         s5_k1_ff <= s4_k1_ff;
         s5_tx_ff <= s4_tx_ff;
         s5_ty_ff <= s4_ty_ff;
         s5_p1_ff <= s4_p1_ff;
         s5_p2_ff <= s4_p2_ff;
         s5_nx_ff <= s4_nx_ff;
         s5_ny_ff <= s4_ny_ff;

         s6_kr_ff <= a6kr.val;
         s6_tx_ff <= s5_tx_ff;
         s6_ty_ff <= s5_ty_ff;
         s6_p1_ff <= s5_p1_ff;
         s6_p2_ff <= s5_p2_ff;
         s6_nx_ff <= s5_nx_ff;
         s6_ny_ff <= s5_ny_ff;

         s7_a_ff  <= m7a.val;
         s7_b_ff  <= m7b.val;
         s7_tx_ff <= s6_tx_ff;
         s7_ty_ff <= s6_ty_ff;
         s7_p1_ff <= s6_p1_ff;
         s7_p2_ff <= s6_p2_ff;

         s8_dx_ff <= a8dx.val;
         s8_dy_ff <= a8dy.val;

         // depth zero overrides everything else
         if (zro_ff[NSTG-1]) begin
            u_ff      <= 32'sd0;
            v_ff      <= 32'sd0;
            status_ff <= STATUS_DIV_ERR;
         end else begin
            u_ff      <= m9u.val;
            v_ff      <= m9v.val;
            status_ff <= (sat_ff[NSTG-1] | m9u.sat | m9v.sat) ? STATUS_SAT : STATUS_OK;
         end
      end
   end

   assign out_valid  = vld_ff[NSTG];
   assign out_u      = u_ff;
   assign out_v      = v_ff;
   assign out_status = status_ff;

endmodule
